[sv/euclidean_signed_divider_top_defines.svh]
// Assertion macros used by the divider top level.
`ifndef EUCLIDEAN_SIGNED_DIVIDER_TOP_DEFINES_SVH
`define EUCLIDEAN_SIGNED_DIVIDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/esd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = (DATA_WIDTH > 2) ? $clog2(DATA_WIDTH) : 1;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [DATA_WIDTH-2:0] t_rem;
    typedef logic [CNT_W-1:0]      t_cnt;

    localparam t_word MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] divisor;
    } t_esd_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        logic        [DATA_WIDTH-2:0] remainder;
        logic                         zero_divisor;
        logic                         overflow;
    } t_esd_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_SGN
    } t_esd_state;

    function automatic t_word negate(input t_word v);
        return t_word'(~v + t_word'(1));
    endfunction

endpackage

`default_nettype wire

[sv/euclidean_signed_divider_top.sv]
// An accepted item passes through the divide, fix and sign states before its result is registered.
// A zero divisor skips the divide and fix states and goes straight to the sign state.
// A new item is taken only while idle; the divide loop produces one quotient bit per cycle.
// busy is high from acceptance until the result is registered; the result strobe cannot stall.
// Reset is synchronous, active low; it returns the block to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "euclidean_signed_divider_top_defines.svh"

module euclidean_signed_divider_top
    import esd_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    input  t_esd_in  i_req,
    output logic     busy,
    output logic     o_valid,
    output t_esd_out o_res
);

    t_esd_state r_state, n_state;
    logic       r_aneg,  n_aneg;
    logic       r_bneg,  n_bneg;
    logic       r_zero,  n_zero;
    t_word      r_mb,    n_mb;
    t_word      r_q,     n_q;
    t_word      r_rem,   n_rem;
    logic       r_valid, n_valid;
    t_esd_out   r_res,   n_res;

    logic  div_load;
    logic  div_done;
    t_word div_quot;
    t_word div_rem;
    t_word in_a;
    t_word in_b;
    t_word ma;
    t_word mb;
    logic  qneg;

    assign in_a = t_word'(i_req.dividend);
    assign in_b = t_word'(i_req.divisor);
    assign ma   = in_a[DATA_WIDTH-1] ? negate(in_a) : in_a;
    assign mb   = in_b[DATA_WIDTH-1] ? negate(in_b) : in_b;
    assign qneg = r_aneg ^ r_bneg;

    esd_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (div_load),
        .i_dividend  (ma),
        .i_divisor   (mb),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state  = r_state;
        n_aneg   = r_aneg;
        n_bneg   = r_bneg;
        n_zero   = r_zero;
        n_mb     = r_mb;
        n_q      = r_q;
        n_rem    = r_rem;
        n_valid  = 1'b0;
        n_res    = r_res;
        div_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_aneg = in_a[DATA_WIDTH-1];
                    n_bneg = in_b[DATA_WIDTH-1];
                    n_zero = (in_b == '0);
                    n_mb   = mb;
                    if (in_b == '0) begin
                        n_state = S_SGN;
                    end else begin
                        div_load = 1'b1;
                        n_state  = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_q     = div_quot;
                    n_rem   = div_rem;
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // A negative dividend adjusts the quotient so the remainder is non-negative.
                if (r_aneg && (r_rem != '0)) begin
                    n_q   = t_word'(r_q + t_word'(1));
                    n_rem = t_word'(r_mb - r_rem);
                end
                n_state = S_SGN;
            end
            S_SGN: begin
                n_valid = 1'b1;
                n_res   = '0;
                if (r_zero) begin
                    n_res.zero_divisor = 1'b1;
                end else if (!qneg && (r_q > MAXPOS)) begin
                    n_res.quotient = MAXPOS;
                    n_res.overflow = 1'b1;
                end else begin
                    n_res.quotient  = qneg ? negate(r_q) : r_q;
                    n_res.remainder = r_rem[DATA_WIDTH-2:0];
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_aneg <= n_aneg;
        r_bneg <= n_bneg;
        r_zero <= n_zero;
        r_mb   <= n_mb;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_res  <= n_res;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    `ESD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted item did not raise busy")
    `ESD_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, o_valid,
        !(o_res.zero_divisor && o_res.overflow), "zero divisor and overflow both set")
    `ESD_ASSERT_NOW(a_zero_result, i_clk, i_rst_n, o_valid && o_res.zero_divisor,
        (o_res.quotient == '0) && (o_res.remainder == '0), "zero divisor result not cleared")
    `ESD_ASSERT_NOW(a_ovf_sat, i_clk, i_rst_n, o_valid && o_res.overflow,
        (o_res.quotient == MAXPOS) && (o_res.remainder == '0), "overflow result not saturated")
    `ESD_ASSERT_NOW(a_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV,
        "divider finished outside the divide state")

endmodule

`default_nettype wire

[sv/esd_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module esd_divider
    import esd_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_load,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output logic  o_done,
    output t_word o_quotient,
    output t_word o_remainder
);

    logic  r_busy, n_busy;
    logic  r_done, n_done;
    t_cnt  r_cnt,  n_cnt;
    t_word r_qsh,  n_qsh;
    t_word r_rem,  n_rem;
    t_word r_div,  n_div;

    logic [DATA_WIDTH:0] trial;
    t_word               shifted;
    logic                ge;

    always_comb begin
        // The partial remainder stays below the divisor, so its top bit is free.
        shifted = {r_rem[DATA_WIDTH-2:0], r_qsh[DATA_WIDTH-1]};
        trial   = {1'b0, shifted} - {1'b0, r_div};
        ge      = ~trial[DATA_WIDTH];

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_qsh  = r_qsh;
        n_rem  = r_rem;
        n_div  = r_div;

        if (i_load) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_qsh  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? trial[DATA_WIDTH-1:0] : shifted;
            n_qsh = {r_qsh[DATA_WIDTH-2:0], ge};
            n_cnt = t_cnt'(r_cnt + t_cnt'(1));
            if (r_cnt == t_cnt'(DATA_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_qsh <= n_qsh;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_qsh;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire
